/* design/mipi_pkg.sv */
// Shared types and constants for the multi-instance PI controller.
package mipi_pkg;

  // Field widths of the input beat
  localparam int IDX_W  = 7;
  localparam int DATA_W = 32;
  localparam int IN_W   = 200;   // 7 + 6*32 bits, padded to whole bytes

  // Register map: one 32-bit register, word index taken from paddr[2]
  localparam logic REG_SAMPLE_PERIOD = 1'b0;
  localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd42949673;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KE,      // ki*error
    ST_PE,      // kp*error, |ki*error|, integrator load
    ST_LO,      // low half of |ki*error| times dt, round kp*error
    ST_HI,      // high half of |ki*error| times dt
    ST_SUM,     // add the two partial products
    ST_INC,     // sign and saturate the increment
    ST_INTEG,   // update, clamp and store the integrator
    ST_DRIVE    // form the output, wait for the output register
  } state_t;

  // Datapath operations, one per sequencer step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_KE,
    OP_PE,
    OP_LO,
    OP_HI,
    OP_SUM,
    OP_INC,
    OP_INTEG,
    OP_DRIVE
  } op_t;

  typedef struct packed {
    logic load;   // capture the input beat
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
  } sts_t;

endpackage

/* design/mipi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mipi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/mipi_ctrl.sv */
// Step sequencer for the PI controller datapath.
module mipi_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output mipi_pkg::cmd_t cmd,
  input  mipi_pkg::sts_t sts
);

  import mipi_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd.load  = 1'b0;
    cmd.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_KE;
        end
      end
      ST_KE: begin
        cmd.op    = OP_KE;
        state_nxt = ST_PE;
      end
      ST_PE: begin
        cmd.op    = OP_PE;
        state_nxt = ST_LO;
      end
      ST_LO: begin
        cmd.op    = OP_LO;
        state_nxt = ST_HI;
      end
      ST_HI: begin
        cmd.op    = OP_HI;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = ST_INC;
      end
      ST_INC: begin
        cmd.op    = OP_INC;
        state_nxt = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.op    = OP_INTEG;
        state_nxt = ST_DRIVE;
      end
      ST_DRIVE: begin
        cmd.op = OP_DRIVE;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/mipi_dp.sv */
// Datapath: shared multiplier, rounding, saturation, integrator store, output register.
module mipi_dp #(
  parameter int NUM_INSTANCES = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mipi_pkg::cmd_t              cmd,
  output mipi_pkg::sts_t              sts,
  input  logic [mipi_pkg::IN_W-1:0]   in_tdata,
  input  logic [31:0]                 sample_period,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mipi_pkg::DATA_W-1:0] out_tdata
);

  import mipi_pkg::*;

  localparam int AW = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;
  localparam int IDX_VALS = 2 ** IDX_W;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Saturate a wide signed value to the Q16.16 range
  function automatic logic signed [31:0] sat_q(input logic signed [48:0] x);
    logic signed [31:0] r;
    if (x > 49'(Q_MAX)) begin
      r = Q_MAX;
    end else if (x < 49'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Clamp to [lo, hi]; inverted limits give hi
  function automatic logic signed [31:0] clamp_q(input logic signed [31:0] x,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    logic signed [31:0] r;
    r = (x > lo) ? x : lo;
    return (r < hi) ? r : hi;
  endfunction

  // Instance index reduction table (built at elaboration)
  logic [AW-1:0] mod_tbl [IDX_VALS];
  for (genvar g = 0; g < IDX_VALS; g++) begin : g_mod
    assign mod_tbl[g] = AW'(g % NUM_INSTANCES);
  end

  // Captured beat
  logic [AW-1:0]      idx_r;
  logic signed [31:0] err_r, kp_r, ki_r, lo_r, hi_r, i0_r;

  // Working registers
  logic signed [63:0] p_r;        // multiplier output
  logic [63:0]        m_r;        // |ki*error|
  logic               neg_r;
  logic signed [31:0] prop_r;
  logic [32:0]        acc_r;      // carry from low partial product plus rounding
  logic [63:0]        t_r;
  logic signed [31:0] inc_r;
  logic signed [31:0] integ_r;
  logic               flags_r [NUM_INSTANCES];
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  // Shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  // Combinational step results
  logic signed [63:0] prop_sum;
  logic signed [47:0] prop_q;
  logic [47:0]        inc_mag;
  logic signed [48:0] inc_sgn;
  logic signed [31:0] integ_new;
  logic signed [31:0] drive_new;
  logic [31:0]        ram_rdata;
  logic               out_free;

  always_comb begin
    unique case (cmd.op)
      OP_KE: begin
        mul_a = {ki_r[31], ki_r};
        mul_b = {err_r[31], err_r};
      end
      OP_PE: begin
        mul_a = {kp_r[31], kp_r};
        mul_b = {err_r[31], err_r};
      end
      OP_LO: begin
        mul_a = {1'b0, m_r[31:0]};
        mul_b = {1'b0, sample_period};
      end
      OP_HI: begin
        mul_a = {1'b0, m_r[63:32]};
        mul_b = {1'b0, sample_period};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Round kp*error to nearest, ties away from zero, in signed form
  assign prop_sum = p_r + (p_r[63] ? 64'sd32767 : 64'sd32768);
  assign prop_q   = prop_sum[63:16];

  // Apply the sign to the increment magnitude
  assign inc_mag = t_r[63:16];
  assign inc_sgn = neg_r ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});

  // Integrator update and output
  assign integ_new = clamp_q(sat_q(49'(integ_r) + 49'(inc_r)), lo_r, hi_r);
  assign drive_new = clamp_q(sat_q(49'(prop_r) + 49'(integ_r)), lo_r, hi_r);

  assign out_free     = !out_valid_r || out_tready;
  assign sts.out_free = out_free;

  // Input capture and arithmetic steps
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= mod_tbl[in_tdata[IDX_W-1:0]];
      err_r <= in_tdata[38:7];
      kp_r  <= in_tdata[70:39];
      ki_r  <= in_tdata[102:71];
      lo_r  <= in_tdata[134:103];
      hi_r  <= in_tdata[166:135];
      i0_r  <= in_tdata[198:167];
    end
    unique case (cmd.op)
      OP_KE: begin
        p_r <= mul_p[63:0];
      end
      OP_PE: begin
        p_r     <= mul_p[63:0];
        neg_r   <= p_r[63];
        m_r     <= p_r[63] ? 64'(-p_r) : 64'(p_r);
        integ_r <= flags_r[idx_r] ? $signed(ram_rdata) : i0_r;
      end
      OP_LO: begin
        p_r    <= mul_p[63:0];
        prop_r <= sat_q(49'(prop_q));
      end
      OP_HI: begin
        p_r   <= mul_p[63:0];
        acc_r <= {1'b0, p_r[63:32]} + 33'd32768;
      end
      OP_SUM: begin
        t_r <= 64'(p_r) + {31'b0, acc_r};
      end
      OP_INC: begin
        inc_r <= sat_q(inc_sgn);
      end
      OP_INTEG: begin
        integ_r <= integ_new;
      end
      OP_NONE, OP_DRIVE: begin
      end
      default: begin
      end
    endcase
  end

  // First-use flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_INSTANCES; i++) begin
        flags_r[i] <= 1'b0;
      end
    end else if (cmd.op == OP_INTEG) begin
      flags_r[idx_r] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_DRIVE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DRIVE && out_free) begin
      out_data_r <= drive_new;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Integrator store
  mipi_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_INSTANCES)
  ) u_integ_ram (
    .clk   (clk),
    .we    (cmd.op == OP_INTEG),
    .waddr (idx_r),
    .wdata (integ_new),
    .re    (cmd.op == OP_KE),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

endmodule

/* design/multi_instance_pi_controller.sv */
// Top level: configuration register, sequencer and datapath of the PI controller.
//
// A PI controller shared by NUM_INSTANCES instances, each with its own integrator
// held in a RAM with one write port and one registered read port. One beat on the
// input stream is one controller step and yields one beat on the output stream.
// A step runs from the accepting edge until its result sits in the output register,
// and no new beat is accepted while a step is in progress: the four products
// (ki*error, kp*error and the two halves of |ki*error|*sample_period) go one
// after another through a single 33x33 multiplier, followed by rounding,
// saturation, integrator write-back and output stages. The next beat is taken
// in the cycle after the result is loaded; a result that is not taken holds the
// block in its last step. First-use flags sit in flip-flops cleared by reset, so
// there is no clearing pass. sample_period lives at byte address 0 and should be
// written only while no step is in progress.
module multi_instance_pi_controller #(
  parameter int NUM_INSTANCES = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata, from bit 0: instance_index[6:0], error_value, proportional_gain,
  // integral_gain, lower_limit, upper_limit, initial_integral, 1 pad bit
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [199:0] in_tdata,
  // out_tdata, from bit 0: drive_value
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,
  // configuration port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  import mipi_pkg::*;

  logic [31:0] sample_period_r;
  logic        cfg_wr;
  cmd_t        cmd;
  sts_t        sts;

  // Register write and read-back
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= SAMPLE_PERIOD_RST;
    end else if (cfg_wr && cfg_paddr[2] == REG_SAMPLE_PERIOD) begin
      sample_period_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_SAMPLE_PERIOD) ? sample_period_r : 32'd0;

  // Sequencer
  mipi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath
  mipi_dp #(
    .NUM_INSTANCES (NUM_INSTANCES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_tdata      (in_tdata),
    .sample_period (sample_period_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the multi-instance PI controller.
`timescale 1ns / 1ps

module tb_top;
  import mipi_pkg::*;

  localparam int NUM_INST = 128;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int LONG_HOLD = 200;
  localparam int LONG_HOLD_AT = 350;

  // one controller step, first field in the low bits
  typedef struct packed {
    logic               pad;
    logic signed [31:0] init_integ;
    logic signed [31:0] upper;
    logic signed [31:0] lower;
    logic signed [31:0] ki;
    logic signed [31:0] kp;
    logic signed [31:0] err;
    logic [IDX_W-1:0]   inst;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;    // inst, err, kp, ki, lower, upper, init_integ, pad
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;        // drive_value
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [2:0]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  multi_instance_pi_controller #(.NUM_INSTANCES(NUM_INST)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // shadow state of the controller
  logic [31:0]        period_cfg;
  logic signed [31:0] integ_mem [NUM_INST];
  bit                 started [NUM_INST];

  step_t       step_q[$];
  logic [31:0] drive_q[$];

  int idle_pct = 0;
  int err_cnt = 0;
  int steps_taken = 0;
  int beats_checked = 0;
  int periods_used = 1;
  int gap_left = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  // ---------------------------------------------------------------- predictor
  function automatic longint sat_q16(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint clamp_lim(longint x, longint lo, longint hi);
    longint r;
    r = (x > lo) ? x : lo;
    return (r < hi) ? r : hi;
  endfunction

  // kp*err, Q32.32 -> Q16.16, round half away from zero
  function automatic longint prop_term(int kp, int err);
    longint p;
    logic [63:0] m;
    longint q;
    p = longint'(kp) * longint'(err);
    m = (p < 0) ? -p : p;
    q = longint'((m + 64'd32768) >> 16);
    return sat_q16((p < 0) ? -q : q);
  endfunction

  // period*ki*err, Q32.64 -> Q16.16, round half away from zero
  function automatic longint integ_incr(logic [31:0] period, int ki, int err);
    longint p;
    logic [63:0] m;
    logic [95:0] w;
    logic [63:0] t;
    longint q;
    p = longint'(ki) * longint'(err);
    m = (p < 0) ? -p : p;
    w = {32'b0, m} * {64'b0, period};
    t = w[95:32] + 64'd32768;
    q = longint'(t >> 16);
    return sat_q16((p < 0) ? -q : q);
  endfunction

  function automatic logic [31:0] predict_drive(step_t s);
    int k;
    longint lo, hi, integ, drive;
    k = int'(s.inst) % NUM_INST;
    lo = longint'(s.lower);
    hi = longint'(s.upper);
    if (!started[k]) begin
      integ_mem[k] = s.init_integ;
      started[k] = 1'b1;
    end
    integ = sat_q16(longint'(integ_mem[k]) + integ_incr(period_cfg, s.ki, s.err));
    integ = clamp_lim(integ, lo, hi);
    integ_mem[k] = integ[31:0];
    drive = clamp_lim(sat_q16(prop_term(s.kp, s.err) + integ), lo, hi);
    return drive[31:0];
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        drive_q.push_back(predict_drive(in_tdata));
        steps_taken++;
      end
      if (in_tvalid && !in_tready) begin
        // beat still waiting, hold it
      end else if (gap_left != 0) begin
        in_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (step_q.size() != 0 && idle_pct != 0 &&
                   $urandom_range(1, 100) <= idle_pct) begin
        in_tvalid <= 1'b0;
        gap_left <= $urandom_range(0, 12);
      end else if (step_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= step_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (drive_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected drive beat, expected none, actual %h",
                   $time, out_tdata);
        end else begin
          logic [31:0] exp_drive;
          exp_drive = drive_q.pop_front();
          if (out_tdata !== exp_drive) begin
            err_cnt++;
            $display("%0t: drive_value mismatch, expected %h, actual %h",
                     $time, exp_drive, out_tdata);
          end
        end
        beats_checked++;
      end
      // long stall once, otherwise random bursts
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!long_hold_done && beats_checked >= LONG_HOLD_AT) begin
        out_tready <= 1'b0;
        hold_left <= LONG_HOLD - 1;
        long_hold_done <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_tready <= 1'b0;
        hold_left <= $urandom_range(0, 12);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic step_t mk_step(int inst, int err, int kp, int ki,
                                    int lo, int hi, int i0);
    step_t s;
    s.pad = 1'b0;
    s.inst = inst[IDX_W-1:0];
    s.err = err;
    s.kp = kp;
    s.ki = ki;
    s.lower = lo;
    s.upper = hi;
    s.init_integ = i0;
    return s;
  endfunction

  // mix of small values, full-range noise and extremes
  function automatic int rand_q16();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v = $urandom_range(0, 32'h0020_0000);
        return v - 32'h0010_0000;
      end
      4, 5, 6: return $urandom;
      7: return 32'h8000_0000;
      8: return 32'h7FFF_FFFF;
      default: return int'($urandom_range(0, 2)) - 1;
    endcase
  endfunction

  // bounded value in Q16.16 units: +-range whole units
  function automatic int rand_units(int range);
    int v;
    v = $urandom_range(0, 2 * range * 65536);
    return v - range * 65536;
  endfunction

  function automatic step_t rand_step();
    step_t s;
    int a, b;
    if ($urandom_range(1, 10) <= 7) begin
      // regular loop traffic on a few instances with ordered limits
      a = -int'($urandom_range(0, 200 * 65536));
      b = $urandom_range(0, 200 * 65536);
      s = mk_step($urandom_range(0, 11), rand_units(4), rand_units(8), rand_units(50),
                  a, b, rand_units(100));
    end else begin
      s = mk_step($urandom_range(0, NUM_INST - 1), rand_q16(), rand_q16(), rand_q16(),
                  rand_q16(), rand_q16(), rand_q16());
    end
    return s;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (step_q.size() != 0 || in_tvalid || drive_q.size() != 0);
  endtask

  // register write followed by a read back
  task automatic set_sample_period(logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {REG_SAMPLE_PERIOD, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    period_cfg = v;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (cfg_prdata !== v) begin
      err_cnt++;
      $display("%0t: sample_period read back, expected %h, actual %h",
               $time, v, cfg_prdata);
    end
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    periods_used++;
  endtask

  initial begin
    logic [31:0] periods [6];
    int phase_pct [6];
    period_cfg = SAMPLE_PERIOD_RST;
    foreach (started[i]) begin
      started[i] = 1'b0;
      integ_mem[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed steps at the reset sample period
    @(negedge clk);
    idle_pct = 10;
    step_q.push_back(mk_step(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                             -32'h0064_0000, 32'h0064_0000, 32'h0005_0000));
    step_q.push_back(mk_step(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                             -32'h0064_0000, 32'h0064_0000, 32'h7FFF_0000));
    // first use with a start value above the upper limit
    step_q.push_back(mk_step(127, 0, 32'h0002_0000, 32'h0001_0000,
                             -32'h0010_0000, 32'h0010_0000, 32'h0050_0000));
    // inverted limits
    step_q.push_back(mk_step(127, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000,
                             32'h0010_0000, -32'h0010_0000, 0));
    step_q.push_back(mk_step(9, -32'h0003_0000, 32'h0002_0000, 32'h0004_0000,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678));
    // products that saturate both ways
    step_q.push_back(mk_step(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF, 0));
    step_q.push_back(mk_step(2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h7FFF_FFFF, 0));
    step_q.push_back(mk_step(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF, 0));
    // rounding ties on the proportional term
    step_q.push_back(mk_step(4, 32'h0000_8000, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    step_q.push_back(mk_step(5, -32'h0000_8000, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    step_q.push_back(mk_step(6, 32'h0000_7FFF, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    // integrator sums that hit the numeric range
    step_q.push_back(mk_step(7, 32'h8000_0000, 0, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    step_q.push_back(mk_step(8, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    step_q.push_back(mk_step(8, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF, 0));
    // equal limits, all-ones and all-zeros beats
    step_q.push_back(mk_step(10, 32'h0004_0000, 32'h0003_0000, 32'h0002_0000,
                             32'h0001_8000, 32'h0001_8000, -32'h0001_0000));
    step_q.push_back(mk_step(127, -1, -1, -1, -1, -1, -1));
    step_q.push_back(mk_step(11, 0, 0, 0, 0, 0, 0));
    step_q.push_back(mk_step(0, -32'h0002_0000, 32'h0000_4000, -32'h0008_0000,
                             -32'h0064_0000, 32'h0064_0000, 0));
    wait_idle();

    // random phases, one sample period each
    periods = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h0000_0001,
                32'h8000_0000, SAMPLE_PERIOD_RST};
    phase_pct = '{8, 15, 0, 5, 12, 0};
    for (int ph = 0; ph < 6; ph++) begin
      set_sample_period(periods[ph]);
      @(negedge clk);
      idle_pct = phase_pct[ph];
      for (int n = 0; n < 230; n++) step_q.push_back(rand_step());
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("%0d controller steps over %0d sample period settings, %0d drive beats checked",
             steps_taken, periods_used, beats_checked);
    $display("random source/sink gaps, one %0d-cycle output stall, %0d mismatches",
             LONG_HOLD, err_cnt);
    if (err_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("%0t: timeout with %0d drive beats outstanding", $time, drive_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule
